>>> rtl/core/grapheme_cluster_width_tracker_assert.svh
// assertion macros for the grapheme cluster width tracker
`ifndef GRAPHEME_CLUSTER_WIDTH_TRACKER_ASSERT_SVH
`define GRAPHEME_CLUSTER_WIDTH_TRACKER_ASSERT_SVH

// condition must hold in the same cycle
`define GCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define GCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gcw_pkg.sv
// shared types and constants for the grapheme cluster width tracker
`timescale 1ns / 1ps

package gcw_pkg;

    localparam int TOTAL_BITS_DEF = 8;
    localparam int TOTAL_BITS_MAX = 16;
    localparam int WIDE_BITS      = TOTAL_BITS_MAX + 2;
    localparam int CP_BITS        = 21;
    localparam int WIDTH_BITS     = 7;

    localparam logic [CP_BITS-1:0] CP_ZWJ     = 21'h0200D;
    localparam logic [CP_BITS-1:0] CP_VS16    = 21'h0FE0F;
    localparam logic [CP_BITS-1:0] CP_VS15    = 21'h0FE0E;
    localparam logic [CP_BITS-1:0] CP_TONE_LO = 21'h1F3FB;
    localparam logic [CP_BITS-1:0] CP_TONE_HI = 21'h1F3FF;

    localparam logic [WIDTH_BITS-1:0] WIDTH_CAP = 7'd127;

    // bit positions in base_props
    localparam int PROP_PICT  = 0;
    localparam int PROP_RI    = 1;
    localparam int PROP_VBASE = 2;
    localparam int PROP_ONE   = 3;

    typedef struct packed {
        logic [CP_BITS-1:0] code_point;
        logic [1:0]         cell_width;
        logic               is_regional_indicator;
        logic               is_pictographic;
        logic               is_variation_base;
        logic               is_virama_mark;
        logic               is_spacing_mark;
        logic               starts_cluster;
    } t_item;

    typedef struct packed {
        logic [1:0] open_width;
        logic       indicator_run_odd;
        logic       skip_following;
        logic       after_virama;
        logic       base_open;
        logic [1:0] base_recorded_width;
        logic [3:0] base_props;
    } t_ctl;

endpackage

>>> rtl/core/grapheme_cluster_width_tracker.sv
// Grapheme cluster width tracker: takes one codepoint with its Unicode properties per
// transaction and returns the terminal column width of the cluster so far, clamped to
// 0..127. One transaction is accepted every clock cycle; the result appears in the
// output register in the cycle after acceptance. The whole update is a single
// combinational pass from the input port through the tracking state into the output
// register, and the output register is refilled in the same cycle that it drains, so
// the input stalls only while a result waits unread or reset is held. The running
// total saturates at the signed TOTAL_BITS range.
`timescale 1ns / 1ps

module grapheme_cluster_width_tracker #(
    parameter int TOTAL_BITS = gcw_pkg::TOTAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // code_point, zero pad
    // cell_width, is_regional_indicator, is_pictographic, is_variation_base,
    // is_virama_mark, is_spacing_mark, starts_cluster
    input  logic [7:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // cluster_width, zero pad
);
    import gcw_pkg::*;

    t_item                          item;
    t_ctl                           r_ctl;
    t_ctl                           n_ctl;
    logic signed [TOTAL_BITS-1:0]   r_total;
    logic signed [TOTAL_BITS-1:0]   n_total;
    logic [WIDTH_BITS-1:0]          n_width;
    logic [WIDTH_BITS-1:0]          r_width;
    logic                           r_out_valid;
    logic                           s_accept;

    assign o_s_tready = i_rst_n & (~r_out_valid | i_m_tready);
    assign s_accept   = i_s_tvalid & o_s_tready;

    always_comb begin
        item.code_point            = i_s_tdata[CP_BITS-1:0];
        item.cell_width            = i_s_tuser[1:0];
        item.is_regional_indicator = i_s_tuser[2];
        item.is_pictographic       = i_s_tuser[3];
        item.is_variation_base     = i_s_tuser[4];
        item.is_virama_mark        = i_s_tuser[5];
        item.is_spacing_mark       = i_s_tuser[6];
        item.starts_cluster        = i_s_tuser[7];
    end

    gcw_step #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_step (
        .i_item  (item),
        .i_ctl   (r_ctl),
        .i_total (r_total),
        .o_ctl   (n_ctl),
        .o_total (n_total),
        .o_width (n_width)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_ctl       <= n_ctl;
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_width <= n_width;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_width};

`include "grapheme_cluster_width_tracker_assert.svh"

    `GCW_ASSERT_NEXT(a_accept_fills_out, i_clk, i_rst_n, s_accept, r_out_valid, "accepted transaction produced no result")
    `GCW_ASSERT_NOW(a_open_width_range, i_clk, i_rst_n, 1'b1, r_ctl.open_width != 2'd3, "open width out of range")
    `GCW_ASSERT_NOW(a_base_width_range, i_clk, i_rst_n, 1'b1, r_ctl.base_recorded_width != 2'd3, "recorded base width out of range")
    `GCW_ASSERT_NEXT(a_lone_zwj_zero, i_clk, i_rst_n, s_accept && item.starts_cluster && item.code_point == CP_ZWJ, r_width == '0 && r_ctl.skip_following, "lone zwj cluster not zero width")

endmodule

>>> rtl/core/gcw_step.sv
// per-codepoint width update: next tracking state and cluster width
`timescale 1ns / 1ps

module gcw_step #(
    parameter int TOTAL_BITS = gcw_pkg::TOTAL_BITS_DEF
) (
    input  gcw_pkg::t_item                          i_item,
    input  gcw_pkg::t_ctl                           i_ctl,
    input  logic signed [TOTAL_BITS-1:0]            i_total,
    output gcw_pkg::t_ctl                           o_ctl,
    output logic signed [TOTAL_BITS-1:0]            o_total,
    output logic [gcw_pkg::WIDTH_BITS-1:0]          o_width
);
    import gcw_pkg::*;

    localparam logic signed [TOTAL_BITS-1:0] T_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] T_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};
    localparam logic signed [TOTAL_BITS-1:0] T_ONE = {{(TOTAL_BITS-1){1'b0}}, 1'b1};

    t_ctl                          cur;
    logic signed [TOTAL_BITS-1:0]  cur_total;
    logic [1:0]                    w;
    logic [3:0]                    props;
    logic                          is_tone;
    logic signed [TOTAL_BITS:0]    add_sum;
    logic signed [TOTAL_BITS-1:0]  add_sat;
    logic signed [TOTAL_BITS-1:0]  dec_sat;
    logic signed [TOTAL_BITS:0]    out_sum;
    logic signed [WIDE_BITS-1:0]   out_wide;

    always_comb begin
        w = (i_item.cell_width == 2'd3) ? 2'd2 : i_item.cell_width;
        props = '0;
        props[PROP_PICT]  = i_item.is_pictographic;
        props[PROP_RI]    = i_item.is_regional_indicator;
        props[PROP_VBASE] = i_item.is_variation_base;
        props[PROP_ONE]   = (w == 2'd1);
        is_tone = i_item.code_point inside {[CP_TONE_LO:CP_TONE_HI]};

        // new cluster clears everything first
        cur       = i_item.starts_cluster ? '0 : i_ctl;
        cur_total = i_item.starts_cluster ? '0 : i_total;

        add_sum = {cur_total[TOTAL_BITS-1], cur_total}
                + $signed({{(TOTAL_BITS-1){1'b0}}, cur.open_width});
        if (add_sum[TOTAL_BITS] != add_sum[TOTAL_BITS-1]) begin
            add_sat = add_sum[TOTAL_BITS] ? T_MIN : T_MAX;
        end else begin
            add_sat = add_sum[TOTAL_BITS-1:0];
        end
        dec_sat = (cur_total == T_MIN) ? T_MIN : cur_total - T_ONE;

        o_ctl   = cur;
        o_total = cur_total;
        o_ctl.indicator_run_odd = i_item.is_regional_indicator & ~cur.indicator_run_odd;

        if (cur.skip_following) begin
            o_ctl.skip_following = 1'b0;
        end else if (i_item.code_point == CP_ZWJ) begin
            if (!cur.after_virama) begin
                o_ctl.skip_following      = 1'b1;
                o_ctl.base_recorded_width = 2'd0;
            end
        end else if (i_item.code_point == CP_VS16 && cur.base_open) begin
            if (cur.base_props[PROP_VBASE] && cur.base_props[PROP_ONE]) begin
                o_ctl.open_width = 2'd2;
            end
            o_ctl.base_open = 1'b0;
        end else if (i_item.code_point == CP_VS15 && cur.base_open) begin
            if (cur.base_props[PROP_VBASE] && cur.base_recorded_width == 2'd2) begin
                o_total = dec_sat;
            end
        end else if (i_item.is_regional_indicator && cur.indicator_run_odd) begin
            o_ctl.base_props = props;
        end else if (is_tone && (cur.base_props[PROP_PICT] || cur.base_props[PROP_RI])) begin
            // tone modifier absorbed by its base
        end else if (w != 2'd0) begin
            if (cur.after_virama) begin
                o_ctl.open_width = 2'd2;
            end else if (cur.open_width != 2'd0) begin
                o_total          = add_sat;
                o_ctl.open_width = w;
            end else begin
                o_ctl.open_width = w;
            end
            o_ctl.base_props          = props;
            o_ctl.base_recorded_width = w;
            o_ctl.base_open           = 1'b1;
            o_ctl.after_virama        = 1'b0;
        end else if (i_item.is_virama_mark) begin
            o_ctl.after_virama = 1'b1;
        end else if (i_item.is_spacing_mark && cur.base_open) begin
            o_ctl.open_width   = 2'd2;
            o_ctl.base_open    = 1'b0;
            o_ctl.after_virama = 1'b0;
        end else begin
            o_ctl.after_virama = 1'b0;
        end

        out_sum  = {o_total[TOTAL_BITS-1], o_total}
                 + $signed({{(TOTAL_BITS-1){1'b0}}, o_ctl.open_width});
        out_wide = {{(WIDE_BITS-TOTAL_BITS-1){out_sum[TOTAL_BITS]}}, out_sum};
        if (out_wide[WIDE_BITS-1]) begin
            o_width = '0;
        end else if (out_wide > $signed({{(WIDE_BITS-WIDTH_BITS){1'b0}}, WIDTH_CAP})) begin
            o_width = WIDTH_CAP;
        end else begin
            o_width = out_wide[WIDTH_BITS-1:0];
        end
    end

endmodule
